>>> src/crri_pkg.sv
// Shared types and constants for the CIGAR reference-to-read index block.
`default_nettype none

package crri_pkg;

  // Widths of the input fields.
  localparam int CigarLenWidth = 28;
  localparam int InPosWidth    = 31;

  // CIGAR operation codes.
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_P  = 4'd6;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // What an operation does to the walk.
  typedef enum logic [1:0] {
    CLS_MATCH = 2'd0,  // advances read and reference
    CLS_READ  = 2'd1,  // advances the read only
    CLS_REF   = 2'd2,  // advances the reference only
    CLS_NONE  = 2'd3   // changes nothing
  } op_class_e;

  typedef struct packed {
    op_class_e cls;
    logic      first;
    logic      last;
  } op_ctrl_t;

endpackage

`default_nettype wire

>>> src/crri_front.sv
// Front end: classifies each CIGAR word and clamps the start and target positions.
`default_nettype none

module crri_front
  import crri_pkg::*;
#(
  parameter int PosWidth = 32
) (
  input  wire logic [3:0]            cigar_op_i,
  input  wire logic [InPosWidth-1:0] align_start_i,
  input  wire logic [InPosWidth-1:0] target_pos_i,
  input  wire logic                  first_op_i,
  input  wire logic                  last_op_i,
  output op_ctrl_t                   ctrl_o,
  output logic [PosWidth-2:0]        start_o,
  output logic [PosWidth-2:0]        target_o
);

  localparam int W = PosWidth - 1;
  localparam logic [W-1:0] PosMax = {W{1'b1}};

  op_class_e cls;

  always_comb begin
    unique case (cigar_op_i)
      OP_M, OP_EQ, OP_X: cls = CLS_MATCH;
      OP_I, OP_S:        cls = CLS_READ;
      OP_D, OP_N:        cls = CLS_REF;
      OP_H, OP_P:        cls = CLS_NONE;
      default:           cls = CLS_NONE;
    endcase
  end

  assign ctrl_o.cls   = cls;
  assign ctrl_o.first = first_op_i;
  assign ctrl_o.last  = last_op_i;

  // Positions above the largest representable one are pinned to it.
  assign start_o  = (align_start_i > InPosWidth'(PosMax)) ? PosMax : align_start_i[W-1:0];
  assign target_o = (target_pos_i > InPosWidth'(PosMax)) ? PosMax : target_pos_i[W-1:0];

endmodule

`default_nettype wire

>>> src/crri_queue.sv
// Two-entry queue that decouples the front end from the walk.
`default_nettype none

module crri_queue #(
  parameter int DataWidth = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [DataWidth-1:0] data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output logic [DataWidth-1:0]      data_o,
  output logic [1:0]                count_o
);

  logic [DataWidth-1:0] mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

>>> src/crri_back.sv
// Back end: walks read and reference offsets and holds the result register.
`default_nettype none

module crri_back
  import crri_pkg::*;
#(
  parameter int PosWidth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  input  wire op_ctrl_t                 ctrl_i,
  input  wire logic [CigarLenWidth-1:0] len_i,
  input  wire logic [PosWidth-2:0]      start_i,
  input  wire logic [PosWidth-2:0]      target_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          covered_o,
  output logic [PosWidth-2:0]           index_o
);

  localparam int W  = PosWidth - 1;
  localparam int SW = ((W > CigarLenWidth) ? W : CigarLenWidth) + 1;
  localparam logic [W-1:0] PosMax = {W{1'b1}};

  logic [W-1:0] read_q, read_d, ref_q, ref_d, qry_q, qry_d, idx_q, idx_d;
  logic         set_q, set_d, cov_q, cov_d;
  logic         out_valid_q, out_valid_d, out_cov_q, out_cov_d;
  logic [W-1:0] out_idx_q, out_idx_d;

  logic [W-1:0]  cur_read, cur_ref, cur_qry, cur_idx;
  logic          cur_set, cur_cov;
  logic [SW-1:0] ref_sum, read_sum;
  logic          reaches;
  logic [W-1:0]  ref_adv, read_adv;
  logic [W:0]    read_qry, diff;
  logic          idx_neg;
  logic [W-1:0]  idx_sat;
  logic          out_free;

  // A new read restarts the walk before its first operation is applied.
  always_comb begin
    cur_read = ctrl_i.first ? '0       : read_q;
    cur_ref  = ctrl_i.first ? start_i  : ref_q;
    cur_qry  = ctrl_i.first ? target_i : qry_q;
    cur_set  = ctrl_i.first ? 1'b0     : set_q;
    cur_cov  = ctrl_i.first ? 1'b0     : cov_q;
    cur_idx  = ctrl_i.first ? '0       : idx_q;
  end

  always_comb begin
    ref_sum  = SW'(cur_ref) + SW'(len_i);
    read_sum = SW'(cur_read) + SW'(len_i);
    reaches  = ref_sum > SW'(cur_qry);
    ref_adv  = (ref_sum > SW'(PosMax)) ? PosMax : ref_sum[W-1:0];
    read_adv = (read_sum > SW'(PosMax)) ? PosMax : read_sum[W-1:0];
    // Index = read + target - ref; negative when the op starts past the target.
    read_qry = {1'b0, cur_read} + {1'b0, cur_qry};
    idx_neg  = read_qry < {1'b0, cur_ref};
    diff     = read_qry - {1'b0, cur_ref};
    idx_sat  = diff[W] ? PosMax : diff[W-1:0];
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = q_valid_i && (!ctrl_i.last || out_free);

  always_comb begin
    read_d = cur_read;
    ref_d  = cur_ref;
    qry_d  = cur_qry;
    set_d  = cur_set;
    cov_d  = cur_cov;
    idx_d  = cur_idx;
    if (!cur_set) begin
      unique case (ctrl_i.cls)
        CLS_MATCH: begin
          if (reaches) begin
            set_d = 1'b1;
            cov_d = !idx_neg;
            idx_d = idx_neg ? '0 : idx_sat;
          end else begin
            read_d = read_adv;
            ref_d  = ref_adv;
          end
        end
        CLS_READ: begin
          read_d = read_adv;
        end
        CLS_REF: begin
          if (reaches) begin
            set_d = 1'b1;
            cov_d = 1'b0;
            idx_d = '0;
          end else begin
            ref_d = ref_adv;
          end
        end
        CLS_NONE: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_cov_d   = out_cov_q;
    out_idx_d   = out_idx_q;
    if (pop_o && ctrl_i.last) begin
      out_valid_d = 1'b1;
      out_cov_d   = set_d && cov_d;
      out_idx_d   = (set_d && cov_d) ? idx_d : '0;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q      <= '0;
      ref_q       <= '0;
      qry_q       <= '0;
      set_q       <= 1'b0;
      cov_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        read_q <= read_d;
        ref_q  <= ref_d;
        qry_q  <= qry_d;
        set_q  <= set_d;
        cov_q  <= cov_d;
        idx_q  <= idx_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cov_q <= out_cov_d;
    out_idx_q <= out_idx_d;
  end

  assign out_valid_o = out_valid_q;
  assign covered_o   = out_cov_q;
  assign index_o     = out_idx_q;

endmodule

`default_nettype wire

>>> src/cigar_ref_to_read_index.sv
// Top level: maps a reference position to a read base index from CIGAR words.
// Throughput: one CIGAR word per clock cycle, unless a last word meets a stalled output.
// Path: an accepted CIGAR word is written into the queue; a read's last word loads the
// result register when it is popped with the output free.
// Reset: rst_ni clears the walk state, empties the queue and drops out_valid_o; the
// block can take words as soon as reset is released.
`default_nettype none

module cigar_ref_to_read_index
  import crri_pkg::*;
#(
  parameter int PosWidth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [3:0]               cigar_op_i,
  input  wire logic [CigarLenWidth-1:0] cigar_len_i,
  input  wire logic [InPosWidth-1:0]    align_start_i,
  input  wire logic [InPosWidth-1:0]    target_pos_i,
  input  wire logic                     first_op_i,
  input  wire logic                     last_op_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          covered_o,
  output logic [InPosWidth-1:0]         base_index_o
);

  // Walk positions carry PosWidth-1 bits; they saturate at all ones.
  localparam int W = PosWidth - 1;
  localparam logic [W-1:0] PosMax = {W{1'b1}};
  localparam int CtrlWidth = $bits(op_ctrl_t);
  localparam int DataWidth = CtrlWidth + CigarLenWidth + 2 * W;

  op_ctrl_t             f_ctrl, b_ctrl;
  logic [W-1:0]         f_start, f_target, b_start, b_target;
  logic [CigarLenWidth-1:0] b_len;
  logic [DataWidth-1:0] q_wdata, q_rdata;
  logic                 q_full, q_valid, push, pop;
  logic [1:0]           q_count;
  logic [W-1:0]         index;

  // The front end decodes the word; the queue only fills while the walk stalls
  // on a full result register.
  crri_front #(
    .PosWidth(PosWidth)
  ) u_front (
    .cigar_op_i   (cigar_op_i),
    .align_start_i(align_start_i),
    .target_pos_i (target_pos_i),
    .first_op_i   (first_op_i),
    .last_op_i    (last_op_i),
    .ctrl_o       (f_ctrl),
    .start_o      (f_start),
    .target_o     (f_target)
  );

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;
  assign q_wdata    = {f_ctrl, cigar_len_i, f_start, f_target};

  crri_queue #(
    .DataWidth(DataWidth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_rdata),
    .count_o(q_count)
  );

  assign {b_ctrl, b_len, b_start, b_target} = q_rdata;

  // The back end applies one operation per cycle while the queue holds words, holds a read's
  // last word until the result register is free, and then loads the result register from it.
  crri_back #(
    .PosWidth(PosWidth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .ctrl_i     (b_ctrl),
    .len_i      (b_len),
    .start_i    (b_start),
    .target_i   (b_target),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .covered_o  (covered_o),
    .index_o    (index)
  );

  assign base_index_o = InPosWidth'(index);

  // A word leaves the queue only when one is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("queue popped while empty");

  // The queue never holds more than its two entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count != 2'd3) && !(q_full && push))
    else $error("queue overflow");

  // An uncovered result always reports index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !covered_o) |-> (base_index_o == '0))
    else $error("nonzero index on uncovered result");

  // A reported index never exceeds the saturation limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (base_index_o <= InPosWidth'(PosMax)))
    else $error("base index above saturation limit");

endmodule

`default_nettype wire

>>> sim/cigar_ref_to_read_index_tb.sv
// Self-checking testbench for the CIGAR reference-to-read index block.

module cigar_ref_to_read_index_tb;
  import crri_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block runs at its default position width. Every position and index
  // saturates at PosMax, which for 32 bits equals the largest 31-bit field.
  localparam int          PosWidth   = 32;
  localparam logic [63:0] PosMax     = (64'd1 << (PosWidth - 1)) - 64'd1;
  localparam logic [InPosWidth-1:0]    FieldMax = '1;
  localparam logic [CigarLenWidth-1:0] LenMax   = '1;

  // Op codes 9 to 15 have no meaning and must leave the walk alone.
  localparam logic [3:0] OpUnusedLo = 4'd9;
  localparam logic [3:0] OpUnusedHi = 4'd15;

  // Run length and pacing. A result passes the queue and the result register
  // after its last word; a short drain covers anything emitted by mistake.
  localparam int RandWords   = 1650;
  localparam int CalmWords   = 250;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 40;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;
  localparam int PrintLimit  = 100;

  // One CIGAR word as it crosses the input port.
  typedef struct packed {
    logic [3:0]               op;
    logic [CigarLenWidth-1:0] len;
    logic [InPosWidth-1:0]    start;
    logic [InPosWidth-1:0]    target;
    logic                     first;
    logic                     last;
  } cigar_word_t;

  // One answer word from the output port.
  typedef struct packed {
    logic                  covered;
    logic [InPosWidth-1:0] idx;
  } read_hit_t;

  // A row of the directed table. Where typed is set, the answer written in
  // the row replaces the predicted one.
  typedef struct packed {
    cigar_word_t word;
    bit          typed;
    read_hit_t   hit;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [3:0]               cigar_op_i;
  logic [CigarLenWidth-1:0] cigar_len_i;
  logic [InPosWidth-1:0]    align_start_i;
  logic [InPosWidth-1:0]    target_pos_i;
  logic                     first_op_i;
  logic                     last_op_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     covered_o;
  logic [InPosWidth-1:0]    base_index_o;

  cigar_ref_to_read_index #(
    .PosWidth(PosWidth)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cigar_op_i   (cigar_op_i),
    .cigar_len_i  (cigar_len_i),
    .align_start_i(align_start_i),
    .target_pos_i (target_pos_i),
    .first_op_i   (first_op_i),
    .last_op_i    (last_op_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .covered_o    (covered_o),
    .base_index_o (base_index_o)
  );

  always #10 clk_i = ~clk_i;

  // Answers owed by the block, oldest first.
  read_hit_t hits_due[$];
  dir_row_t  dir_rows[$];

  int  mismatches    = 0;
  int  words_sent    = 0;
  int  results_seen  = 0;
  int  cycle_count   = 0;
  bit  final_stretch = 1'b0;
  bit  held_off      = 1'b0;

  // Private copy of the walk. It starts from the same all-zero state that
  // reset leaves in the block.
  logic [31:0] walk_read  = '0;
  logic [31:0] walk_ref   = '0;
  logic [31:0] walk_tgt   = '0;
  bit          walk_found = 1'b0;
  bit          walk_cov   = 1'b0;
  logic [31:0] walk_idx   = '0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  function automatic logic [31:0] clamp_pos(input logic [63:0] v);
    return (v > PosMax) ? PosMax[31:0] : v[31:0];
  endfunction

  // Advances the walk by one accepted word. Returns 1 when the word closes a
  // read, with the answer in hit.
  function automatic bit walk_word(input cigar_word_t w, output read_hit_t hit);
    logic [63:0] reach_sum;
    bit          reaches;
    longint      signed_idx;
    if (w.first) begin
      walk_read  = '0;
      walk_ref   = clamp_pos({33'd0, w.start});
      walk_tgt   = clamp_pos({33'd0, w.target});
      walk_found = 1'b0;
      walk_cov   = 1'b0;
      walk_idx   = '0;
    end
    // The reach test is taken on the exact sum, not the saturated one.
    reach_sum = {32'd0, walk_ref} + {36'd0, w.len};
    reaches   = reach_sum > {32'd0, walk_tgt};
    if (!walk_found) begin
      case (w.op)
        OP_M, OP_EQ, OP_X: begin
          if (reaches) begin
            signed_idx = longint'({32'd0, walk_read}) + longint'({32'd0, walk_tgt})
                       - longint'({32'd0, walk_ref});
            walk_found = 1'b1;
            // An aligned block that starts past the target gives a negative
            // index, which counts as not covered.
            if (signed_idx < 0) begin
              walk_cov = 1'b0;
              walk_idx = '0;
            end else begin
              walk_cov = 1'b1;
              walk_idx = clamp_pos(signed_idx);
            end
          end else begin
            walk_read = clamp_pos({32'd0, walk_read} + {36'd0, w.len});
            walk_ref  = clamp_pos(reach_sum);
          end
        end
        OP_I, OP_S: begin
          walk_read = clamp_pos({32'd0, walk_read} + {36'd0, w.len});
        end
        OP_D, OP_N: begin
          if (reaches) begin
            walk_found = 1'b1;
            walk_cov   = 1'b0;
            walk_idx   = '0;
          end else begin
            walk_ref = clamp_pos(reach_sum);
          end
        end
        default: begin
        end
      endcase
    end
    hit.covered = walk_found && walk_cov;
    hit.idx     = hit.covered ? walk_idx[InPosWidth-1:0] : '0;
    return w.last;
  endfunction

  function automatic void add_row(input logic [3:0] op, input logic [CigarLenWidth-1:0] len,
                                  input logic [InPosWidth-1:0] start,
                                  input logic [InPosWidth-1:0] target,
                                  input bit first, input bit last, input bit typed,
                                  input bit cov, input logic [InPosWidth-1:0] idx);
    dir_row_t row;
    row.word  = '{op: op, len: len, start: start, target: target, first: first, last: last};
    row.typed = typed;
    row.hit   = '{covered: cov, idx: idx};
    dir_rows.push_back(row);
  endfunction

  // Offers one word, holds it steady until the block takes it, then updates
  // the prediction. The sender idles in bursts, in stretches of words.
  task automatic offer_word(input cigar_word_t w, input bit typed, input read_hit_t typed_hit);
    read_hit_t hit;
    int        gap;
    if (!final_stretch && ((words_sent / 200) % 3 != 2) && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cigar_op_i    <= w.op;
    cigar_len_i   <= w.len;
    align_start_i <= w.start;
    target_pos_i  <= w.target;
    first_op_i    <= w.first;
    last_op_i     <= w.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (walk_word(w, hit)) begin
      hits_due.push_back(typed ? typed_hit : hit);
    end
    words_sent++;
  endtask

  // One read of random content. Most reads are well formed, with the target
  // placed just past the alignment start so that the walk actually meets it.
  // About one in ten is noise: random flags, any op code, any field values.
  task automatic send_random_read();
    cigar_word_t           w;
    read_hit_t             no_hit;
    int                    n_ops;
    int                    pick;
    bit                    broken;
    logic [InPosWidth-1:0] start;
    logic [InPosWidth-1:0] target;
    logic [31:0]           tgt_sum;
    no_hit = '0;
    n_ops  = $urandom_range(1, 8);
    broken = ($urandom_range(0, 9) == 0);

    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      start = InPosWidth'($urandom_range(0, 5000));
    end else if (pick < 9) begin
      start = InPosWidth'($urandom);
    end else begin
      start = FieldMax - InPosWidth'($urandom_range(0, 2000));
    end

    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      tgt_sum = {1'b0, start} + $urandom_range(0, 250);
    end else if (pick < 8) begin
      tgt_sum = (start > 300) ? {1'b0, start} - $urandom_range(1, 300) : '0;
    end else begin
      tgt_sum = {1'b0, InPosWidth'($urandom)};
    end
    target = (tgt_sum > {1'b0, FieldMax}) ? FieldMax : tgt_sum[InPosWidth-1:0];

    for (int k = 0; k < n_ops; k++) begin
      pick = $urandom_range(0, 15);
      case (pick)
        0, 1, 2, 3, 4: w.op = OP_M;
        5:       w.op = OP_I;
        6:       w.op = OP_D;
        7:       w.op = OP_N;
        8:       w.op = OP_S;
        9:       w.op = OP_H;
        10:      w.op = OP_P;
        11, 12:  w.op = OP_EQ;
        13:      w.op = OP_X;
        default: w.op = 4'($urandom_range(OpUnusedHi, OpUnusedLo));
      endcase
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
        w.len = LenMax;
      end else if (pick < 3) begin
        w.len = CigarLenWidth'($urandom);
      end else begin
        w.len = CigarLenWidth'($urandom_range(0, 60));
      end
      w.first = (k == 0);
      w.last  = (k == n_ops - 1);
      // Position fields only count on the first word; elsewhere they carry junk.
      w.start  = w.first ? start : InPosWidth'($urandom);
      w.target = w.first ? target : InPosWidth'($urandom);
      if (broken) begin
        w.op     = 4'($urandom_range(0, 15));
        w.first  = 1'($urandom_range(0, 1));
        w.last   = 1'($urandom_range(0, 1));
        w.start  = InPosWidth'($urandom);
        w.target = InPosWidth'($urandom);
      end
      offer_word(w, 1'b0, no_hit);
    end
  endtask

  // Every answer the block hands over is matched against the oldest one owed.
  always @(posedge clk_i) begin : check_results
    read_hit_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (hits_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word covered=%0b base_index=%0d",
                                covered_o, base_index_o));
      end else begin
        due = hits_due.pop_front();
        if (covered_o !== due.covered) begin
          flag_mismatch($sformatf("covered %0b, expected %0b", covered_o, due.covered));
        end
        if (base_index_o !== due.idx) begin
          flag_mismatch($sformatf("base_index %0d, expected %0d", base_index_o, due.idx));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver side. Once enough answers have come back it refuses output for
  // a long stretch, so the queue fills and the block stalls its input while
  // the sender keeps offering. Otherwise it stalls in short random bursts,
  // in some stretches of the run not at all, and never near the end.
  initial begin : drive_stall
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && results_seen >= HoldAfter) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!final_stretch && ((cycle_count / 1024) % 3 != 1)
                   && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  initial begin : run_test
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cigar_op_i    = '0;
    cigar_len_i   = '0;
    align_start_i = '0;
    target_pos_i  = '0;
    first_op_i    = 1'b0;
    last_op_i     = 1'b0;

    // Directed table: op, len, start, target, first, last, typed, covered, index.
    // A word without a first-op flag right after reset walks from position
    // zero, so an aligned block hits target zero at read index zero.
    add_row(OP_M, 5, 77, 77, 0, 1, 1, 1, 0);
    // Soft clip, then hard clip, padding and an unused code, which change
    // nothing, then a match block: index is 3 clipped bases plus 5.
    add_row(OP_S, 3, 100, 105, 1, 0, 0, 0, 0);
    add_row(OP_H, 9, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_P, 9, 0, 0, 0, 0, 0, 0, 0);
    add_row(OpUnusedHi, LenMax, FieldMax, FieldMax, 0, 0, 0, 0, 0);
    add_row(OP_EQ, 10, 0, 0, 0, 1, 1, 1, 8);
    // A deletion that spans the target leaves it uncovered.
    add_row(OP_M, 5, 0, 7, 1, 0, 0, 0, 0);
    add_row(OP_D, 5, 0, 0, 0, 1, 1, 0, 0);
    // A skipped region that starts on the target, in a one-word read.
    add_row(OP_N, 1, 20, 20, 1, 1, 1, 0, 0);
    // A mismatch block that starts past the target gives a negative index.
    add_row(OP_X, 1, 50, 10, 1, 1, 1, 0, 0);
    // Once settled, the rest of the read is skipped.
    add_row(OP_M, 10, 0, 3, 1, 0, 0, 0, 0);
    add_row(OP_I, 100, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_D, 100, 0, 0, 0, 1, 1, 1, 3);
    // Start and target at the top with a zero-length block: never reached.
    add_row(OP_M, 0, FieldMax, FieldMax, 1, 1, 1, 0, 0);
    // Nine full-length insertions push the read offset into saturation, so
    // the index of the following match saturates as well.
    add_row(OP_I, LenMax, 0, 5, 1, 0, 0, 0, 0);
    for (int k = 0; k < 8; k++) begin
      add_row(OP_I, LenMax, 0, 0, 0, 0, 0, 0, 0);
    end
    add_row(OP_M, 10, 0, 0, 0, 1, 1, 1, FieldMax);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].hit);
    end
    while (words_sent < dir_rows.size() + RandWords) begin
      if (words_sent >= dir_rows.size() + RandWords - CalmWords) begin
        final_stretch = 1'b1;
      end
      send_random_read();
    end
    in_valid_i <= 1'b0;

    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/crri_pkg.sv
src/crri_front.sv
src/crri_queue.sv
src/crri_back.sv
src/cigar_ref_to_read_index.sv
sim/cigar_ref_to_read_index_tb.sv
